[rtl/lkvc_pkg.sv]
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;
    localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } func_t;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic load;
    } cell_ctrl_t;

endpackage

[rtl/lkvc_req_if.sv]
`timescale 1ns / 1ps

interface lkvc_req_if;

    logic                             valid;
    logic                             ready;
    logic                             func;
    logic signed [lkvc_pkg::KEY_W-1:0] key;
    logic signed [lkvc_pkg::VAL_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink (input valid, input func, input key, input value, output ready);

endinterface

[rtl/lkvc_rsp_if.sv]
`timescale 1ns / 1ps

interface lkvc_rsp_if;

    logic                              valid;
    logic                              ready;
    logic                              found;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value;
    logic                              evicted;

    modport source (output valid, output found, output read_value, output evicted,
                    input ready);
    modport sink (input valid, input found, input read_value, input evicted,
                  output ready);

endinterface

[rtl/lkvc_cfg_if.sv]
`timescale 1ns / 1ps

interface lkvc_cfg_if;

    logic                        valid;
    logic                        ready;
    logic [lkvc_pkg::CAP_W-1:0]  capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);

endinterface

[rtl/lkvc_cell.sv]
`timescale 1ns / 1ps

module lkvc_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lkvc_pkg::cell_ctrl_t               ctrl,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  lookup_key,
    input  lkvc_pkg::entry_t                   nb_entry,
    output lkvc_pkg::entry_t                   entry,
    output logic                               match
);

    logic                              valid_reg;
    logic signed [lkvc_pkg::KEY_W-1:0] key_reg;
    logic signed [lkvc_pkg::VAL_W-1:0] value_reg;
    logic                              match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                valid_reg <= nb_entry.valid;
            end
            if (ctrl.capture)
            begin
                match_reg <= valid_reg && (key_reg == lookup_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_reg   <= nb_entry.key;
            value_reg <= nb_entry.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;
    assign match       = match_reg;

endmodule

[rtl/lru_key_value_cache_core.sv]
`timescale 1ns / 1ps
// A request beat is taken only while no other request is in flight, so the cache works on
// one request at a time. On acceptance the key is compared in every cell of the recency
// chain and the match is registered; then the chain shifts and the response is registered.
// A stalled response holds the chain update until the response slot frees.
// Reset clears all entries, the live count and the pending work, and sets capacity to 16.

module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lkvc_req_if.sink   req,
    lkvc_rsp_if.source rsp,
    lkvc_cfg_if.sink   cfg
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;
    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_ENTRIES);

    logic [lkvc_pkg::CAP_W-1:0]        capacity_reg;
    logic [CW-1:0]                     live_reg;
    logic [CW-1:0]                     live_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              func_reg;
    logic signed [lkvc_pkg::KEY_W-1:0] key_reg;
    logic signed [lkvc_pkg::VAL_W-1:0] value_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              found_reg;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value_reg;
    logic                              evicted_reg;

    lkvc_pkg::entry_t     entries [MAX_ENTRIES];
    lkvc_pkg::cell_ctrl_t ctrls   [MAX_ENTRIES];
    lkvc_pkg::entry_t     front;
    logic [MAX_ENTRIES-1:0] hit_vec;

    logic                              accept;
    logic                              done;
    logic                              update;
    logic                              hit;
    logic [IW-1:0]                     hit_idx;
    logic signed [lkvc_pkg::VAL_W-1:0] hit_value;
    logic                              is_put;
    logic                              insert;
    logic                              evict;
    logic [CMPW-1:0]                   cap_ext;
    logic [CMPW-1:0]                   eff_cap;
    logic [CW-1:0]                     limit;

    assign accept    = req.valid && req.ready;
    assign req.ready = !busy_reg;
    assign cfg.ready = 1'b1;
    assign done      = busy_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                hit_idx   = hit_idx | IW'(i);
                hit_value = hit_value | entries[i].value;
            end
        end
    end

    always_comb
    begin
        hit     = |hit_vec;
        is_put  = (func_reg == lkvc_pkg::FUNC_PUT);
        insert  = is_put && !hit;
        cap_ext = CMPW'(capacity_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > MAX_C)
        begin
            eff_cap = MAX_C;
        end
        else
        begin
            eff_cap = cap_ext;
        end
        evict  = insert && (CMPW'(live_reg) >= eff_cap);
        update = done && (hit || is_put);
        if (hit)
        begin
            limit = CW'(hit_idx) + CW'(1);
        end
        else if (evict)
        begin
            limit = live_reg;
        end
        else
        begin
            limit = live_reg + CW'(1);
        end
    end

    // The entry that lands at the most recent end of the chain.
    always_comb
    begin
        front.valid = 1'b1;
        front.key   = key_reg;
        front.value = is_put ? value_reg : hit_value;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            ctrls[i].capture = accept;
            ctrls[i].load    = update && ((i == 0) || (CW'(i) < limit));
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            lkvc_pkg::entry_t nb;
            if (g == 0)
            begin : g_head
                assign nb = front;
            end
            else
            begin : g_body
                assign nb = entries[g-1];
            end
            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrls[g]),
                .lookup_key (req.key),
                .nb_entry   (nb),
                .entry      (entries[g]),
                .match      (hit_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        live_next = live_reg;
        if (done && insert && !evict)
        begin
            live_next = live_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= lkvc_pkg::CAP_RESET;
            live_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                capacity_reg <= cfg.capacity;
            end
            live_reg      <= live_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= req.func;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        if (done)
        begin
            found_reg   <= hit;
            evicted_reg <= evict;
            if (is_put)
            begin
                read_value_reg <= lkvc_pkg::PUT_VALUE;
            end
            else if (hit)
            begin
                read_value_reg <= hit_value;
            end
            else
            begin
                read_value_reg <= lkvc_pkg::MISS_VALUE;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.evicted    = evicted_reg;

endmodule

[rtl/lkvc_checker.sv]
`timescale 1ns / 1ps

module lkvc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic                              rsp_found,
    input logic signed [lkvc_pkg::VAL_W-1:0] rsp_read_value,
    input logic                              rsp_evicted
);

    // A pending response beat stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    // A stalled response beat keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_read_value)
            && $stable(rsp_evicted))
        else $error("response payload changed while stalled");

    // The cache works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // An eviction only comes from a put of a new key.
    a_evict_is_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_evicted |-> !rsp_found && (rsp_read_value == lkvc_pkg::PUT_VALUE))
        else $error("eviction reported on a hit or a get");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_read_value (rsp.read_value),
    .rsp_evicted    (rsp.evicted)
);
